@@ hw/rtl/tra_pkg.sv @@
// ----------------------------------------------------------------------------
// Temporal reprojection accumulator package
// Shared widths, constants, codes and control structs.
// ----------------------------------------------------------------------------
package tra_pkg;

   // Field widths fixed by the pixel format.
   localparam int COLOR_W = 16;
   localparam int DEPTH_W = 32;
   localparam int UV_W    = 20;
   localparam int FRAC_W  = 16;
   localparam int LANES   = 4;
   localparam int CHANS   = 3;

   // Depth test limit (0.1 in Q16.16) and confidence base (0.95 in Q0.16).
   localparam int          DIFF_LIMIT = 6554;
   localparam logic [15:0] CONF_BASE  = 16'd62259;

   typedef enum logic {
      OP_PIXEL        = 1'b0,
      OP_END_OF_FRAME = 1'b1
   } op_type;

   typedef enum logic {
      CSR_PROJECTION_ENABLE   = 1'b0,
      CSR_CAMERA_DEPTH_OFFSET = 1'b1
   } csr_index_type;

   // Three Q8.8 channels, red in the lowest bits.
   typedef logic [CHANS*COLOR_W-1:0] rgb_type;

   // Control from the pipeline to the frame stores.
   typedef struct packed {
      logic       rd_en;
      logic       rd_bank;
      logic       wr_en;
      logic       wr_bank;
      logic [1:0] wr_lane;
   } store_ctrl_type;

endpackage

@@ hw/rtl/tra_req_if.sv @@
// ----------------------------------------------------------------------------
// Pixel request channel
// Valid/ready channel carrying one pixel or end-of-frame item.
// ----------------------------------------------------------------------------
interface tra_req_if import tra_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [9:0]                pixel_x;
   logic [8:0]                pixel_y;
   logic [COLOR_W-1:0]        new_red;
   logic [COLOR_W-1:0]        new_green;
   logic [COLOR_W-1:0]        new_blue;
   logic [DEPTH_W-1:0]        hit_depth;
   logic signed [UV_W-1:0]    prev_u;
   logic signed [UV_W-1:0]    prev_v;

   modport source (output valid, operation, pixel_x, pixel_y, new_red, new_green,
                   new_blue, hit_depth, prev_u, prev_v, input ready);
   modport sink   (input valid, operation, pixel_x, pixel_y, new_red, new_green,
                   new_blue, hit_depth, prev_u, prev_v, output ready);
endinterface

@@ hw/rtl/tra_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Pixel response channel
// Valid/ready channel carrying one blended colour per pixel.
// ----------------------------------------------------------------------------
interface tra_rsp_if import tra_pkg::*;;
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] out_red;
   logic [COLOR_W-1:0] out_green;
   logic [COLOR_W-1:0] out_blue;
   logic               history_used;

   modport source (output valid, out_red, out_green, out_blue, history_used,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, history_used,
                   output ready);
endinterface

@@ hw/rtl/tra_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tra_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             re,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (re) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hw/rtl/tra_store.sv @@
// ----------------------------------------------------------------------------
// Ping-pong frame stores
// Two banks, each split into four colour and depth RAM pairs by pixel
// column and row parity, so that the four bilinear neighbours are read in
// the same cycle. Clears all RAMs after reset.
// ----------------------------------------------------------------------------
module tra_store import tra_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  store_ctrl_type     ctrl,
   input  logic [AW-1:0]      rd_addr [LANES],
   input  logic [AW-1:0]      rd_depth_addr,
   input  logic [AW-1:0]      wr_addr,
   input  rgb_type            wr_color,
   input  logic [DEPTH_W-1:0] wr_depth,
   output rgb_type            rd_color [LANES],
   output logic [DEPTH_W-1:0] rd_depth [LANES],
   output logic               clear_busy
);
   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   rgb_type            col_q [2][LANES];
   logic [DEPTH_W-1:0] dep_q [2][LANES];

   // Clearing pass: one address of every RAM per cycle.
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign clear_busy = clearing_ff;

   // RAM array: bank b, parity lane l = {row parity, column parity}.
   for (genvar b = 0; b < 2; b++) begin : g_bank
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         localparam logic [1:0] LANE = 2'(l);
         localparam logic       BANK = 1'(b);
         logic          we;
         logic [AW-1:0] waddr;
         rgb_type            wcol;
         logic [DEPTH_W-1:0] wdep;

         always_comb begin
            we    = clearing_ff ||
                    (ctrl.wr_en && ctrl.wr_bank == BANK && ctrl.wr_lane == LANE);
            waddr = clearing_ff ? clr_addr_ff : wr_addr;
            wcol  = clearing_ff ? '0 : wr_color;
            wdep  = clearing_ff ? '0 : wr_depth;
         end

         tra_ram #(.WIDTH(CHANS*COLOR_W), .DEPTH(DEPTH)) u_color (
            .clock   (clock),
            .we      (we),
            .wr_addr (waddr),
            .wr_data (wcol),
            .re      (ctrl.rd_en),
            .rd_addr (rd_addr[l]),
            .rd_data (col_q[b][l])
         );

         tra_ram #(.WIDTH(DEPTH_W), .DEPTH(DEPTH)) u_depth (
            .clock   (clock),
            .we      (we),
            .wr_addr (waddr),
            .wr_data (wdep),
            .re      (ctrl.rd_en),
            .rd_addr (rd_depth_addr),
            .rd_data (dep_q[b][l])
         );
      end
   end

   // The previous-frame bank does not change while items are in flight.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         rd_color[l] = ctrl.rd_bank ? col_q[1][l] : col_q[0][l];
         rd_depth[l] = ctrl.rd_bank ? dep_q[1][l] : dep_q[0][l];
      end
   end
endmodule

@@ hw/rtl/temporal_reprojection_accumulator.sv @@
// ----------------------------------------------------------------------------
// Temporal reprojection accumulator
// Blends each new pixel colour with a bilinear sample of the previous frame
// when the reprojected depth agrees, and stores the result in ping-pong
// frame stores.
//
//   Channel       Direction  Handshake          Carries
//   req_channel   in         valid / ready      pixel item or end of frame
//   rsp_channel   out        valid / ready      blended colour, history flag
//   csr_*         in         write enable only  projection enable, depth offset
//
// One pixel is taken per cycle unless the output stalls. Four parity lanes
// per bank give all five history reads in the same cycle. An end-of-frame
// item waits until no pixel is in flight, then flips banks. After reset a
// clearing pass over all ceil(W/2)*ceil(H/2) addresses (131072 at the default
// size) zeroes the stores; no item is taken meanwhile. A stalled output
// freezes the whole pipeline, RAM read registers included.
// ----------------------------------------------------------------------------
module temporal_reprojection_accumulator import tra_pkg::*; #(
   parameter int FRAME_WIDTH  = 1024,
   parameter int FRAME_HEIGHT = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   tra_req_if.sink              req_channel,
   tra_rsp_if.source            rsp_channel,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [DEPTH_W-1:0]   csr_write_data
);
   localparam int     HALF_W = (FRAME_WIDTH + 1) / 2;
   localparam int     HALF_H = (FRAME_HEIGHT + 1) / 2;
   localparam int     QDEPTH = HALF_W * HALF_H;
   localparam int     AW     = $clog2(QDEPTH);
   localparam int     XW     = $clog2(FRAME_WIDTH);
   localparam int     YW     = $clog2(FRAME_HEIGHT);
   localparam int     PW     = UV_W + XW + 2;
   localparam int     QW     = UV_W + YW + 2;
   localparam longint XLIM   = longint'(FRAME_WIDTH - 2) << FRAC_W;
   localparam longint YLIM   = longint'(FRAME_HEIGHT - 2) << FRAC_W;

   typedef struct packed {
      rgb_type            color;
      logic [DEPTH_W-1:0] depth;
      logic               wr_ok;
      logic [1:0]         wr_lane;
      logic [AW-1:0]      wr_addr;
   } carry_type;

   // Configuration and bank state.
   logic                      proj_en_ff, proj_en_in;
   logic signed [DEPTH_W-1:0] depth_off_ff, depth_off_in;
   logic                      bank_ff, bank_in;

   logic adv, accept, pipe_empty, clear_busy;

   // Stage registers.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic [9:0]             s1_px_ff;
   logic [8:0]             s1_py_ff;
   rgb_type                s1_color_ff;
   logic [DEPTH_W-1:0]     s1_depth_ff;
   logic signed [UV_W-1:0] s1_u_ff, s1_v_ff;

   carry_type s2_carry_ff, s2_carry_in, s3_carry_ff, s4_carry_ff, s5_carry_ff, s6_carry_ff;
   logic              s2_hist_ok_ff, s2_hist_ok_in;
   logic [XW-1:0]     s2_ix_ff, s2_ix_in, s2_cx_ff, s2_cx_in;
   logic [YW-1:0]     s2_iy_ff, s2_iy_in, s2_cy_ff, s2_cy_in;
   logic [FRAC_W-1:0] s2_fx_ff, s2_fx_in, s2_fy_ff, s2_fy_in;

   logic        s3_hist_ok_ff;
   logic [1:0]  s3_dlane_ff, s3_dlane_in;
   logic [32:0] s3_weight_ff [LANES];
   logic [32:0] s3_weight_in [LANES];

   logic        s4_hist_ok_ff, s4_diff_ok_ff, s4_diff_ok_in;
   logic [12:0] s4_diff_ff, s4_diff_in;
   logic [48:0] s4_prod_ff [LANES][CHANS];
   logic [48:0] s4_prod_in [LANES][CHANS];

   logic               s5_used_ff, s5_used_in;
   logic [15:0]        s5_conf_ff, s5_conf_in;
   logic [COLOR_W-1:0] s5_hist_ff [CHANS];
   logic [COLOR_W-1:0] s5_hist_in [CHANS];

   logic        s6_used_ff;
   logic [32:0] s6_new_ff [CHANS];
   logic [32:0] s6_new_in [CHANS];
   logic [32:0] s6_old_ff [CHANS];
   logic [32:0] s6_old_in [CHANS];

   logic    rsp_valid_ff, rsp_used_ff;
   rgb_type rsp_color_ff, out_color;

   // Coordinate and store signals.
   logic signed [PW-1:0] pos_x, pos_xr;
   logic signed [QW-1:0] pos_y, pos_yr;
   logic [AW-1:0]        rd_addr [LANES];
   logic [AW-1:0]        rd_depth_addr;
   rgb_type              rd_color [LANES];
   logic [DEPTH_W-1:0]   rd_depth [LANES];
   store_ctrl_type       store_ctrl;

   // Handshake: the whole pipeline moves when the output register can.
   assign adv        = !rsp_valid_ff || rsp_channel.ready;
   assign pipe_empty = !(s1_valid_ff || s2_valid_ff || s3_valid_ff ||
                         s4_valid_ff || s5_valid_ff || s6_valid_ff);
   assign req_channel.ready = adv && !clear_busy &&
                              (req_channel.operation == OP_PIXEL || pipe_empty);
   assign accept = req_channel.valid && req_channel.ready;

   // Configuration writes and bank swap.
   always_comb begin
      proj_en_in   = proj_en_ff;
      depth_off_in = depth_off_ff;
      bank_in      = bank_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PROJECTION_ENABLE:   proj_en_in   = csr_write_data[0];
            CSR_CAMERA_DEPTH_OFFSET: depth_off_in = csr_write_data;
            default:                 proj_en_in   = proj_en_ff;
         endcase
      end
      if (accept && req_channel.operation == OP_END_OF_FRAME) begin
         bank_in = !bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proj_en_ff   <= 1'b1;
         depth_off_ff <= '0;
         bank_ff      <= 1'b0;
      end else begin
         proj_en_ff   <= proj_en_in;
         depth_off_ff <= depth_off_in;
         bank_ff      <= bank_in;
      end
   end

   // Stage 2: scale the coordinate to pixels, border test, write address.
   always_comb begin
      pos_x  = PW'(s1_u_ff) * $signed(PW'(FRAME_WIDTH));
      pos_y  = QW'(s1_v_ff) * $signed(QW'(FRAME_HEIGHT));
      pos_xr = pos_x + PW'(32768);
      pos_yr = pos_y + QW'(32768);
      s2_hist_ok_in = proj_en_ff && pos_x > 0 && pos_x < PW'(XLIM) &&
                      pos_y > 0 && pos_y < QW'(YLIM);
      s2_ix_in = pos_x[XW+FRAC_W-1:FRAC_W];
      s2_iy_in = pos_y[YW+FRAC_W-1:FRAC_W];
      s2_fx_in = pos_x[FRAC_W-1:0];
      s2_fy_in = pos_y[FRAC_W-1:0];
      s2_cx_in = pos_xr[XW+FRAC_W-1:FRAC_W];
      s2_cy_in = pos_yr[YW+FRAC_W-1:FRAC_W];
      s2_carry_in.color   = s1_color_ff;
      s2_carry_in.depth   = s1_depth_ff;
      s2_carry_in.wr_ok   = proj_en_ff && (32'(s1_px_ff) < 32'(FRAME_WIDTH)) &&
                            (32'(s1_py_ff) < 32'(FRAME_HEIGHT));
      s2_carry_in.wr_lane = {s1_py_ff[0], s1_px_ff[0]};
      s2_carry_in.wr_addr = AW'(32'(s1_px_ff[9:1]) + 32'(s1_py_ff[8:1]) * HALF_W);
   end

   // Stage 3: neighbour addresses and bilinear weights per parity lane.
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      localparam logic [1:0] LANE = 2'(l);
      logic          x_odd, y_odd;
      logic [XW-1:0] xs;
      logic [YW-1:0] ys;
      logic [16:0]   wx, wy;
      logic [33:0]   wprod;

      always_comb begin
         x_odd = s2_ix_ff[0] != LANE[0];
         y_odd = s2_iy_ff[0] != LANE[1];
         xs    = s2_ix_ff + XW'(x_odd);
         ys    = s2_iy_ff + YW'(y_odd);
         rd_addr[l] = AW'(32'(xs >> 1) + 32'(ys >> 1) * HALF_W);
         wx = x_odd ? {1'b0, s2_fx_ff} : 17'h10000 - {1'b0, s2_fx_ff};
         wy = y_odd ? {1'b0, s2_fy_ff} : 17'h10000 - {1'b0, s2_fy_ff};
         wprod = 34'(wx) * 34'(wy);
         s3_weight_in[l] = wprod[32:0];
      end
   end

   always_comb begin
      rd_depth_addr = AW'(32'(s2_cx_ff >> 1) + 32'(s2_cy_ff >> 1) * HALF_W);
      s3_dlane_in   = {s2_cy_ff[0], s2_cx_ff[0]};
   end

   // Stage 4: depth difference and weighted colour products.
   logic signed [33:0] target, delta;
   logic [33:0]        mag;
   logic [DEPTH_W-1:0] hist_depth;

   always_comb begin
      hist_depth = rd_depth[s3_dlane_ff];
      target = $signed({2'b00, s3_carry_ff.depth}) + 34'(depth_off_ff);
      delta  = $signed({2'b00, hist_depth}) - target;
      mag    = delta[33] ? 34'(-delta) : 34'(delta);
      s4_diff_ok_in = mag < 34'(DIFF_LIMIT);
      s4_diff_in    = mag[12:0];
      for (int l = 0; l < LANES; l++) begin
         for (int c = 0; c < CHANS; c++) begin
            s4_prod_in[l][c] = 49'(rd_color[l][c*COLOR_W +: COLOR_W]) *
                               49'(s3_weight_ff[l]);
         end
      end
   end

   // Stage 5: bilinear sums rounded to Q8.8, confidence.
   logic [50:0] bsum [CHANS];

   always_comb begin
      s5_used_in = s4_hist_ok_ff && s4_diff_ok_ff;
      s5_conf_in = s5_used_in ? CONF_BASE - 16'(32'(s4_diff_ff) * 3) : 16'd0;
      for (int c = 0; c < CHANS; c++) begin
         bsum[c] = 51'(s4_prod_ff[0][c]) + 51'(s4_prod_ff[1][c]) +
                   51'(s4_prod_ff[2][c]) + 51'(s4_prod_ff[3][c]) + 51'(32'h8000_0000);
         s5_hist_in[c] = bsum[c][47:32];
      end
   end

   // Stage 6: blend products; zero confidence leaves the new colour.
   always_comb begin
      for (int c = 0; c < CHANS; c++) begin
         s6_new_in[c] = 33'(s5_carry_ff.color[c*COLOR_W +: COLOR_W]) *
                        (33'h1_0000 - 33'(s5_conf_ff));
         s6_old_in[c] = 33'(s5_hist_ff[c]) * 33'(s5_conf_ff);
      end
   end

   // Output: round, saturate.
   logic [33:0] bl_sum [CHANS];

   always_comb begin
      for (int c = 0; c < CHANS; c++) begin
         bl_sum[c] = 34'(s6_new_ff[c]) + 34'(s6_old_ff[c]) + 34'(32768);
         out_color[c*COLOR_W +: COLOR_W] = (bl_sum[c][33:32] != 2'b00) ?
                                           16'hFFFF : bl_sum[c][31:16];
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= accept && req_channel.operation == OP_PIXEL;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         rsp_valid_ff <= s6_valid_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_px_ff      <= req_channel.pixel_x;
         s1_py_ff      <= req_channel.pixel_y;
         s1_color_ff   <= {req_channel.new_blue, req_channel.new_green,
                           req_channel.new_red};
         s1_depth_ff   <= req_channel.hit_depth;
         s1_u_ff       <= req_channel.prev_u;
         s1_v_ff       <= req_channel.prev_v;
         s2_carry_ff   <= s2_carry_in;
         s2_hist_ok_ff <= s2_hist_ok_in;
         s2_ix_ff      <= s2_ix_in;
         s2_iy_ff      <= s2_iy_in;
         s2_fx_ff      <= s2_fx_in;
         s2_fy_ff      <= s2_fy_in;
         s2_cx_ff      <= s2_cx_in;
         s2_cy_ff      <= s2_cy_in;
         s3_carry_ff   <= s2_carry_ff;
         s3_hist_ok_ff <= s2_hist_ok_ff;
         s3_dlane_ff   <= s3_dlane_in;
         s3_weight_ff  <= s3_weight_in;
         s4_carry_ff   <= s3_carry_ff;
         s4_hist_ok_ff <= s3_hist_ok_ff;
         s4_diff_ok_ff <= s4_diff_ok_in;
         s4_diff_ff    <= s4_diff_in;
         s4_prod_ff    <= s4_prod_in;
         s5_carry_ff   <= s4_carry_ff;
         s5_used_ff    <= s5_used_in;
         s5_conf_ff    <= s5_conf_in;
         s5_hist_ff    <= s5_hist_in;
         s6_carry_ff   <= s5_carry_ff;
         s6_used_ff    <= s5_used_ff;
         s6_new_ff     <= s6_new_in;
         s6_old_ff     <= s6_old_in;
         rsp_color_ff  <= out_color;
         rsp_used_ff   <= s6_used_ff;
      end
   end

   // Frame stores: read the previous bank, write the current one.
   always_comb begin
      store_ctrl.rd_en   = adv;
      store_ctrl.rd_bank = !bank_ff;
      store_ctrl.wr_en   = adv && s6_valid_ff && s6_carry_ff.wr_ok;
      store_ctrl.wr_bank = bank_ff;
      store_ctrl.wr_lane = s6_carry_ff.wr_lane;
   end

   tra_store #(.DEPTH(QDEPTH), .AW(AW)) u_store (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (store_ctrl),
      .rd_addr       (rd_addr),
      .rd_depth_addr (rd_depth_addr),
      .wr_addr       (s6_carry_ff.wr_addr),
      .wr_color      (out_color),
      .wr_depth      (s6_carry_ff.depth),
      .rd_color      (rd_color),
      .rd_depth      (rd_depth),
      .clear_busy    (clear_busy)
   );

   // Result channel.
   assign rsp_channel.valid        = rsp_valid_ff;
   assign rsp_channel.out_red      = rsp_color_ff[COLOR_W-1:0];
   assign rsp_channel.out_green    = rsp_color_ff[2*COLOR_W-1:COLOR_W];
   assign rsp_channel.out_blue     = rsp_color_ff[3*COLOR_W-1:2*COLOR_W];
   assign rsp_channel.history_used = rsp_used_ff;

   // A bank swap never overtakes a pixel still in flight.
   a_swap_when_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && req_channel.operation == OP_END_OF_FRAME) |-> pipe_empty)
      else $error("bank swap with pixels in flight");

   // No store write while the clearing pass runs.
   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      store_ctrl.wr_en |-> !clear_busy)
      else $error("store write during clearing pass");

   // History use needs projection enabled.
   a_used_needs_enable: assert property (@(posedge clock) disable iff (reset)
      (rsp_channel.valid && rsp_channel.history_used) |-> proj_en_ff)
      else $error("history used while projection disabled");

   // A stalled result holds its value.
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_channel.ready) |=> $stable(rsp_color_ff))
      else $error("result changed under stall");
endmodule

@@ tb/tb_temporal_reprojection_accumulator.sv @@
// ----------------------------------------------------------------------------
// Temporal reprojection accumulator testbench
// Drives pixel and end-of-frame items into the accumulator with bursty
// traffic and a stalling receiver. It keeps its own copy of both frame stores
// to predict each blended colour, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_temporal_reprojection_accumulator import tra_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          FW          = 1024;
   localparam int          FH          = 512;
   localparam int unsigned STORE       = FW * FH;
   localparam int          IDLE_LIMIT  = 400000;
   localparam int          DRAIN_WAIT  = 16;
   localparam int          LONG_HOLD   = 300;
   localparam int          REGION_X    = 200;
   localparam int          REGION_Y    = 100;

   typedef struct {
      op_type            op;
      logic [9:0]        x;
      logic [8:0]        y;
      logic [15:0]       red;
      logic [15:0]       green;
      logic [15:0]       blue;
      logic [31:0]       depth;
      logic signed [19:0] u;
      logic signed [19:0] v;
   } pixel_item_type;

   typedef struct {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        used;
   } blend_result_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_index;
   logic [31:0] csr_write_data;

   tra_req_if req_if ();
   tra_rsp_if rsp_if ();

   temporal_reprojection_accumulator uut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_if),
      .rsp_channel      (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predicted frame stores, keyed by bank * STORE + pixel index.
   logic [47:0] color_mem [int unsigned];
   logic [31:0] depth_mem [int unsigned];
   bit          cur_bank;
   bit          proj_en;
   logic [31:0] depth_offset;

   blend_result_type expected_q [$];
   int               error_count;
   int               hold_req;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Store lookups; entries never written read as zero.
   function automatic logic [15:0] hist_color(input bit bank, input int unsigned idx,
                                              input int ch);
      int unsigned key;
      key = bank * STORE + idx;
      if (!color_mem.exists(key)) return 16'd0;
      return color_mem[key][16*ch +: 16];
   endfunction

   function automatic logic [31:0] hist_depth(input bit bank, input int unsigned idx);
      int unsigned key;
      key = bank * STORE + idx;
      if (!depth_mem.exists(key)) return 32'd0;
      return depth_mem[key];
   endfunction

   // Works out one item's blended colour and, with projection on, updates the stores.
   // Returns zero for an end of frame, which flips the bank and yields no result.
   function automatic bit accumulate_pixel(input pixel_item_type it,
                                           output blend_result_type r);
      longint            p, q, hist, off, diff, conf;
      longint unsigned   fx, fy, w00, w10, w01, w11, s, h, b, cf;
      int unsigned       ix, iy, cx, cy, i00, i01;
      logic [15:0]       nc [3];
      logic [15:0]       rc [3];
      bit                prv;
      r = '{default: '0};
      if (it.op == OP_END_OF_FRAME) begin
         cur_bank ^= 1'b1;
         return 1'b0;
      end
      nc[0] = it.red;
      nc[1] = it.green;
      nc[2] = it.blue;
      rc = nc;
      if (proj_en) begin
         p = longint'(it.u) * FW;
         q = longint'(it.v) * FH;
         prv = ~cur_bank;
         if (p > 0 && p < (longint'(FW - 2) <<< 16) &&
             q > 0 && q < (longint'(FH - 2) <<< 16)) begin
            ix  = 32'(p >>> 16);
            iy  = 32'(q >>> 16);
            fx  = p & 64'hFFFF;
            fy  = q & 64'hFFFF;
            cx  = 32'((p + 32768) >>> 16);
            cy  = 32'((q + 32768) >>> 16);
            w00 = (65536 - fx) * (65536 - fy);
            w10 = fx * (65536 - fy);
            w01 = (65536 - fx) * fy;
            w11 = fx * fy;
            i00 = ix + iy * FW;
            i01 = i00 + FW;
            hist = longint'(hist_depth(prv, cx + cy * FW));
            off  = longint'($signed(depth_offset));
            diff = hist - (longint'(it.depth) + off);
            if (diff < 0) diff = -diff;
            if (diff < DIFF_LIMIT) begin
               conf = longint'(CONF_BASE) - 3 * diff;
               if (conf < 0) conf = 0;
               cf = conf;
               r.used = 1'b1;
               for (int ch = 0; ch < 3; ch++) begin
                  s = hist_color(prv, i00, ch) * w00 + hist_color(prv, i00 + 1, ch) * w10 +
                      hist_color(prv, i01, ch) * w01 + hist_color(prv, i01 + 1, ch) * w11;
                  h = (s + 64'h8000_0000) >> 32;
                  b = (nc[ch] * (65536 - cf) + h * cf + 32768) >> 16;
                  if (b > 64'hFFFF) b = 64'hFFFF;
                  rc[ch] = b[15:0];
               end
            end
         end
         // The pixel fields cannot leave the frame at the default size.
         color_mem[cur_bank * STORE + it.x + it.y * FW] = {rc[2], rc[1], rc[0]};
         depth_mem[cur_bank * STORE + it.x + it.y * FW] = it.depth;
      end
      r.red   = rc[0];
      r.green = rc[1];
      r.blue  = rc[2];
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Offers one item and waits for its transfer; valid stays high afterwards.
   task automatic send_item(input pixel_item_type it);
      blend_result_type r;
      req_if.valid     <= 1'b1;
      req_if.operation <= it.op;
      req_if.pixel_x   <= it.x;
      req_if.pixel_y   <= it.y;
      req_if.new_red   <= it.red;
      req_if.new_green <= it.green;
      req_if.new_blue  <= it.blue;
      req_if.hit_depth <= it.depth;
      req_if.prev_u    <= it.u;
      req_if.prev_v    <= it.v;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (accumulate_pixel(it, r)) expected_q = {expected_q, r};
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         req_if.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Waits for the block to drain, then writes one register.
   task automatic write_csr(input csr_index_type idx, input logic [31:0] data);
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_PROJECTION_ENABLE) proj_en = data[0];
      else depth_offset = data;
   endtask

   function automatic pixel_item_type make_pixel(input int x, input int y,
                                                 input logic [15:0] c,
                                                 input logic [31:0] d, input int u,
                                                 input int v);
      pixel_item_type it;
      it.op    = OP_PIXEL;
      it.x     = 10'(x);
      it.y     = 9'(y);
      it.red   = c;
      it.green = c ^ 16'h5A5A;
      it.blue  = ~c;
      it.depth = d;
      it.u     = 20'(u);
      it.v     = 20'(v);
      return it;
   endfunction

   function automatic pixel_item_type end_of_frame();
      pixel_item_type it;
      it = make_pixel(0, 0, 16'd0, 32'd0, 0, 0);
      it.op = OP_END_OF_FRAME;
      return it;
   endfunction

   // Fully random fields, end of frame now and then.
   function automatic pixel_item_type noise_item();
      pixel_item_type it;
      it.op    = ($urandom_range(0, 9) == 0) ? OP_END_OF_FRAME : OP_PIXEL;
      it.x     = 10'($urandom);
      it.y     = 9'($urandom);
      it.red   = 16'($urandom);
      it.green = 16'($urandom);
      it.blue  = 16'($urandom);
      it.depth = $urandom;
      it.u     = 20'($urandom);
      it.v     = 20'($urandom);
      return it;
   endfunction

   // A pixel in the tracked region whose history coordinate and depth land
   // mostly close to what the previous frame stored there.
   function automatic pixel_item_type tracked_item();
      pixel_item_type it;
      int        tx, ty, fu, fv, cx, cy, sel;
      longint    target, delta;
      tx  = REGION_X + $urandom_range(0, 6);
      ty  = REGION_Y + $urandom_range(0, 4);
      fu  = $urandom_range(0, 63);
      fv  = $urandom_range(0, 127);
      cx  = (tx * 65536 + fu * 1024 + 32768) >> 16;
      cy  = (ty * 65536 + fv * 512 + 32768) >> 16;
      sel = $urandom_range(0, 9);
      if (sel < 7) delta = longint'($urandom_range(0, 4000)) - 2000;
      else if (sel < 9) delta = longint'($urandom_range(0, 13200)) - 6600;
      else delta = longint'($urandom_range(0, 200000)) - 100000;
      target = longint'(hist_depth(~cur_bank, cx + cy * FW)) -
               longint'($signed(depth_offset)) + delta;
      it = make_pixel(REGION_X + $urandom_range(0, 7), REGION_Y + $urandom_range(0, 5),
                      16'($urandom), target[31:0], tx * 64 + fu, ty * 128 + fv);
      it.green = 16'($urandom);
      it.blue  = 16'($urandom);
      return it;
   endfunction

   // Border edges, field extremes and an end of frame.
   task automatic test_border_and_extremes();
      send_item(make_pixel(0, 0, 16'h0000, 32'h0000_0000, 0, 0));
      send_item(make_pixel(1023, 511, 16'hFFFF, 32'hFFFF_FFFF, -524288, -524288));
      send_item(make_pixel(5, 5, 16'h1234, 32'h0001_0000, 524287, 524287));
      send_item(make_pixel(6, 5, 16'h8000, 32'h0, 1, 1));
      send_item(make_pixel(7, 5, 16'h00FF, 32'h0, 65407, 65279));
      send_item(make_pixel(8, 5, 16'hFF00, 32'h0, 65408, 65279));
      send_item(make_pixel(9, 5, 16'hABCD, 32'h0, 65407, 65280));
      send_item(make_pixel(10, 5, 16'h7FFF, 32'h0, -1, 100));
      send_item(end_of_frame());
   endtask

   // Writes a 2x2 patch, swaps, then reads it back around the depth limit.
   task automatic test_history_blend();
      logic [31:0] d;
      d = 32'h0040_0000;
      send_item(make_pixel(20, 20, 16'h1000, d, 0, 0));
      send_item(make_pixel(21, 20, 16'h2000, d, 0, 0));
      send_item(make_pixel(20, 21, 16'h3000, d, 0, 0));
      send_item(make_pixel(21, 21, 16'hFFFF, d, 0, 0));
      send_item(end_of_frame());
      send_item(make_pixel(30, 30, 16'h0000, d, 20 * 64 + 32, 20 * 128 + 64));
      send_item(make_pixel(31, 30, 16'hFFFF, d + 6553, 20 * 64 + 10, 20 * 128 + 100));
      send_item(make_pixel(32, 30, 16'h4444, d - 6553, 20 * 64 + 63, 20 * 128 + 1));
      send_item(make_pixel(33, 30, 16'h4444, d + 6554, 20 * 64 + 32, 20 * 128 + 64));
      send_item(make_pixel(34, 30, 16'h5555, d - 6554, 20 * 64, 20 * 128));
   endtask

   // Pass-through with nothing stored, and two swaps while disabled.
   task automatic test_projection_disabled();
      write_csr(CSR_PROJECTION_ENABLE, 32'd0);
      send_item(make_pixel(20, 20, 16'h9999, 32'h0, 0, 0));
      send_item(make_pixel(40, 40, 16'h1111, 32'h0040_0000, 30 * 64, 30 * 128));
      send_item(end_of_frame());
      send_item(end_of_frame());
      write_csr(CSR_PROJECTION_ENABLE, 32'd1);
      send_item(make_pixel(41, 40, 16'h2222, 32'h0040_0000, 20 * 64 + 5, 20 * 128 + 5));
   endtask

   // Offset extremes applied before the depth test.
   task automatic test_depth_offset();
      write_csr(CSR_CAMERA_DEPTH_OFFSET, 32'h8000_0000);
      send_item(make_pixel(50, 50, 16'h1357, 32'hFFFF_FFFF, 20 * 64 + 8, 20 * 128 + 8));
      write_csr(CSR_CAMERA_DEPTH_OFFSET, 32'h7FFF_FFFF);
      send_item(make_pixel(51, 50, 16'h2468, 32'h0, 20 * 64 + 8, 20 * 128 + 8));
      write_csr(CSR_CAMERA_DEPTH_OFFSET, 32'h0000_0100);
      send_item(make_pixel(52, 50, 16'h3579, 32'h0040_0000 - 32'h100,
                           30 * 64 + 16, 30 * 128 + 16));
      write_csr(CSR_CAMERA_DEPTH_OFFSET, 32'h0);
   endtask

   // Bursty traffic over several register settings, mostly tracked pixels.
   task automatic test_random_traffic();
      int          phase, n, burst;
      logic [31:0] offs [5];
      bit          ens [5];
      offs = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0};
      ens  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
      offs[3] = $urandom;
      offs[4] = $urandom_range(0, 4000) - 2000;
      for (phase = 0; phase < 5; phase++) begin
         write_csr(CSR_PROJECTION_ENABLE, {31'd0, ens[phase]});
         write_csr(CSR_CAMERA_DEPTH_OFFSET, offs[phase]);
         n = 0;
         while (n < 200) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
               if ($urandom_range(0, 19) == 0) send_item(end_of_frame());
               else if ($urandom_range(0, 4) == 0) send_item(noise_item());
               else send_item(tracked_item());
               n++;
            end
            idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
         end
      end
   endtask

   // The receiver holds off for a long stretch while items keep coming.
   task automatic test_backpressure();
      hold_req <= hold_req + 1;
      repeat (60) send_item(tracked_item());
      idle_gap(1);
   endtask

   // Receiver: the stall pattern rotates through four modes, with long holds
   // on request.
   initial begin
      int unsigned cyc;
      int          hold_left;
      int          hold_seen;
      cyc = 0;
      hold_left = 0;
      hold_seen = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case ((cyc / 97) % 4)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Result check against the oldest expectation.
   always @(posedge clock) begin
      blend_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: result transfer with nothing expected", $realtime);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_if.out_red !== want.red)
               report_mismatch("out_red", rsp_if.out_red, want.red);
            if (rsp_if.out_green !== want.green)
               report_mismatch("out_green", rsp_if.out_green, want.green);
            if (rsp_if.out_blue !== want.blue)
               report_mismatch("out_blue", rsp_if.out_blue, want.blue);
            if (rsp_if.history_used !== want.used)
               report_mismatch("history_used", rsp_if.history_used, want.used);
         end
      end
   end

   // Watchdog: too long without any transfer ends the run.
   always @(posedge clock) begin
      int quiet;
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
         $display("tb_temporal_reprojection_accumulator NOT OK");
         $finish;
      end
   end

   // Main sequence.
   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_PROJECTION_ENABLE;
      csr_write_data   = '0;
      req_if.valid     = 1'b0;
      req_if.operation = OP_PIXEL;
      req_if.pixel_x   = '0;
      req_if.pixel_y   = '0;
      req_if.new_red   = '0;
      req_if.new_green = '0;
      req_if.new_blue  = '0;
      req_if.hit_depth = '0;
      req_if.prev_u    = '0;
      req_if.prev_v    = '0;
      error_count      = 0;
      hold_req         = 0;
      cur_bank         = 1'b0;
      proj_en          = 1'b1;
      depth_offset     = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_csr(CSR_PROJECTION_ENABLE, 32'd1);
      write_csr(CSR_CAMERA_DEPTH_OFFSET, 32'd0);

      test_border_and_extremes();
      test_history_blend();
      test_projection_disabled();
      test_depth_offset();
      test_random_traffic();
      test_backpressure();

      // Drain and allow the pipeline to settle.
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_temporal_reprojection_accumulator OK");
      end else begin
         $display("tb_temporal_reprojection_accumulator NOT OK");
      end
      $finish;
   end

endmodule
